// ----- rtl/rtc_time_bcd_codec_macros.svh -----
// Assertion macros shared by the RTC time BCD codec RTL.
`ifndef RTC_TIME_BCD_CODEC_MACROS_SVH
`define RTC_TIME_BCD_CODEC_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define RTCBCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define RTCBCD_ASSERT_IMP(lbl, pre, post, msg) \
  `RTCBCD_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ----- rtl/rtcbcd_pkg.sv -----
// Shared types and constants of the RTC time BCD codec.
package rtcbcd_pkg;

  localparam int unsigned NumRegs = 7;

  // register byte positions
  localparam int unsigned RegSec  = 0;
  localparam int unsigned RegMin  = 1;
  localparam int unsigned RegHour = 2;
  localparam int unsigned RegWday = 3;
  localparam int unsigned RegDate = 4;
  localparam int unsigned RegMon  = 5;
  localparam int unsigned RegYear = 6;

  localparam int unsigned Hr12Bit    = 6;
  localparam int unsigned PmBit      = 5;
  localparam int unsigned CenturyBit = 7;

  localparam logic [7:0] Hr12Flag    = 8'h40;
  localparam logic [7:0] PmFlag      = 8'h20;
  localparam logic [7:0] Mask5       = 8'h1F;
  localparam logic [7:0] Mask6       = 8'h3F;
  localparam logic [7:0] CenturyFlag = 8'h80;
  localparam logic [7:0] YearOffset  = 8'd100;
  localparam logic [7:0] YearMax     = 8'd99;
  localparam logic [8:0] WdayShift   = 9'd12;
  localparam logic [3:0] WdayMod     = 4'd7;

  typedef enum logic {
    ModeDecode = 1'b0,
    ModeEncode = 1'b1
  } mode_e;

  typedef logic [7:0] byte_t;

  // one pipeline lane: seven byte values plus the flags that travel along
  typedef struct packed {
    mode_e                    mode;
    logic [NumRegs-1:0][7:0]  val;
    logic                     twelve;
    logic                     pm;
    logic                     century;
  } lane_t;

endpackage

// ----- rtl/rtcbcd_if.sv -----
// Request and result channel interfaces of the RTC time BCD codec.
interface rtcbcd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [55:0] time_regs;
  logic [5:0]  seconds;
  logic [5:0]  minutes;
  logic [4:0]  hours;
  logic [2:0]  weekday;
  logic [4:0]  date;
  logic [3:0]  month;
  logic [7:0]  year;
  logic        twelve_hour;
  logic        afternoon;

  modport source (
    output valid, mode, time_regs, seconds, minutes, hours, weekday, date, month, year,
           twelve_hour, afternoon,
    input  ready
  );
  modport sink (
    input  valid, mode, time_regs, seconds, minutes, hours, weekday, date, month, year,
           twelve_hour, afternoon,
    output ready
  );
endinterface

interface rtcbcd_out_if;
  logic        valid;
  logic        ready;
  logic [55:0] regs_out;
  logic [7:0]  sec_out;
  logic [7:0]  min_out;
  logic [5:0]  hour_out;
  logic [2:0]  wday_out;
  logic [7:0]  mday_out;
  logic [6:0]  mon_out;
  logic [8:0]  yr_out;
  logic        is_twelve;
  logic        is_pm;

  modport source (
    output valid, regs_out, sec_out, min_out, hour_out, wday_out, mday_out, mon_out,
           yr_out, is_twelve, is_pm,
    input  ready
  );
  modport sink (
    input  valid, regs_out, sec_out, min_out, hour_out, wday_out, mday_out, mon_out,
           yr_out, is_twelve, is_pm,
    output ready
  );
endinterface

// ----- rtl/rtcbcd_prep.sv -----
// Stage 1: flag extraction, masking and encode-side value preparation.
module rtcbcd_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  rtcbcd_in_if.sink           req_i,
  output logic                valid_o,
  output rtcbcd_pkg::lane_t   data_o,
  input  logic                ready_i
);

  rtcbcd_pkg::lane_t   data_d, data_q;
  logic                valid_q;
  rtcbcd_pkg::byte_t   hb, mb;
  logic                yr_hi;

  assign req_i.ready = !valid_q || ready_i;

  always_comb begin
    hb     = req_i.time_regs[8*rtcbcd_pkg::RegHour +: 8];
    mb     = req_i.time_regs[8*rtcbcd_pkg::RegMon +: 8];
    yr_hi  = req_i.year > rtcbcd_pkg::YearMax;
    data_d = '0;
    data_d.mode = rtcbcd_pkg::mode_e'(req_i.mode);
    if (data_d.mode == rtcbcd_pkg::ModeDecode) begin
      for (int k = 0; k < rtcbcd_pkg::NumRegs; k++) begin
        data_d.val[k] = req_i.time_regs[8*k +: 8];
      end
      data_d.twelve  = hb[rtcbcd_pkg::Hr12Bit];
      data_d.pm      = hb[rtcbcd_pkg::Hr12Bit] & hb[rtcbcd_pkg::PmBit];
      data_d.century = mb[rtcbcd_pkg::CenturyBit];
      data_d.val[rtcbcd_pkg::RegHour] = hb[rtcbcd_pkg::Hr12Bit] ? (hb & rtcbcd_pkg::Mask5)
                                                                 : (hb & rtcbcd_pkg::Mask6);
      if (mb[rtcbcd_pkg::CenturyBit]) begin
        data_d.val[rtcbcd_pkg::RegMon] = mb & rtcbcd_pkg::Mask5;
      end
    end else begin
      data_d.val[rtcbcd_pkg::RegSec]  = {2'b00, req_i.seconds};
      data_d.val[rtcbcd_pkg::RegMin]  = {2'b00, req_i.minutes};
      data_d.val[rtcbcd_pkg::RegHour] = {3'b000, req_i.hours};
      // weekday 7 wraps to 0 before the +1
      data_d.val[rtcbcd_pkg::RegWday] = (req_i.weekday == 3'd7) ? 8'd1
                                        : ({5'b00000, req_i.weekday} + 8'd1);
      data_d.val[rtcbcd_pkg::RegDate] = {3'b000, req_i.date};
      data_d.val[rtcbcd_pkg::RegMon]  = {4'b0000, req_i.month};
      data_d.val[rtcbcd_pkg::RegYear] = yr_hi ? (req_i.year - rtcbcd_pkg::YearOffset)
                                              : req_i.year;
      data_d.century = yr_hi;
      data_d.twelve  = req_i.twelve_hour;
      data_d.pm      = req_i.afternoon;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rtcbcd_conv.sv -----
// Stage 2: per-byte BCD to binary or binary to BCD conversion, seven lanes.
module rtcbcd_conv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rtcbcd_pkg::lane_t   data_i,
  output logic                ready_o,
  output logic                valid_o,
  output rtcbcd_pkg::lane_t   data_o,
  input  logic                ready_i
);

  rtcbcd_pkg::lane_t data_d, data_q;
  logic              valid_q;

  // lo + hi * 10, digits unchecked
  function automatic rtcbcd_pkg::byte_t from_bcd(rtcbcd_pkg::byte_t b);
    return {4'b0000, b[3:0]} + {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
  endfunction

  // v / 10 as (v * 205) >> 11, exact over 8 bits
  function automatic rtcbcd_pkg::byte_t to_bcd(rtcbcd_pkg::byte_t v);
    logic [15:0]       prod;
    logic [4:0]        quo;
    rtcbcd_pkg::byte_t rem;
    prod = {8'h00, v} * 16'd205;
    quo  = prod[15:11];
    rem  = v - {quo, 3'b000} - {2'b00, quo, 1'b0};
    return {quo[3:0], rem[3:0]};
  endfunction

  always_comb begin
    data_d = data_i;
    for (int k = 0; k < rtcbcd_pkg::NumRegs; k++) begin
      data_d.val[k] = (data_i.mode == rtcbcd_pkg::ModeDecode) ? from_bcd(data_i.val[k])
                                                             : to_bcd(data_i.val[k]);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/rtcbcd_pack.sv -----
// Stage 3: weekday remap, century year, flag merge and result register.
`include "rtc_time_bcd_codec_macros.svh"

module rtcbcd_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rtcbcd_pkg::lane_t   data_i,
  output logic                ready_o,
  rtcbcd_out_if.source        rsp_o
);

  typedef struct packed {
    logic [55:0] regs_out;
    logic [7:0]  sec_out;
    logic [7:0]  min_out;
    logic [5:0]  hour_out;
    logic [2:0]  wday_out;
    logic [7:0]  mday_out;
    logic [6:0]  mon_out;
    logic [8:0]  yr_out;
    logic        is_twelve;
    logic        is_pm;
  } rsp_t;

  rsp_t              rsp_d, rsp_q;
  logic              valid_q;
  rtcbcd_pkg::byte_t hour_b, mon_b;

  // ((d + 12) mod 7) + 1 by folding base 8 (8 = 1 mod 7)
  function automatic logic [2:0] wday_map(rtcbcd_pkg::byte_t d);
    logic [8:0] x;
    logic [5:0] y;
    logic [3:0] z;
    x = {1'b0, d} + rtcbcd_pkg::WdayShift;
    y = x[8:3] + {3'b000, x[2:0]};
    z = {1'b0, y[5:3]} + {1'b0, y[2:0]};
    if (z >= rtcbcd_pkg::WdayMod) begin
      z = z - rtcbcd_pkg::WdayMod;
    end
    return z[2:0] + 3'd1;
  endfunction

  always_comb begin
    rsp_d  = '0;
    hour_b = data_i.val[rtcbcd_pkg::RegHour];
    mon_b  = data_i.val[rtcbcd_pkg::RegMon];
    if (data_i.mode == rtcbcd_pkg::ModeDecode) begin
      rsp_d.sec_out   = data_i.val[rtcbcd_pkg::RegSec];
      rsp_d.min_out   = data_i.val[rtcbcd_pkg::RegMin];
      rsp_d.hour_out  = hour_b[5:0];
      rsp_d.wday_out  = wday_map(data_i.val[rtcbcd_pkg::RegWday]);
      rsp_d.mday_out  = data_i.val[rtcbcd_pkg::RegDate];
      rsp_d.mon_out   = mon_b[6:0];
      rsp_d.yr_out    = {1'b0, data_i.val[rtcbcd_pkg::RegYear]}
                        + (data_i.century ? {1'b0, rtcbcd_pkg::YearOffset} : 9'd0);
      rsp_d.is_twelve = data_i.twelve;
      rsp_d.is_pm     = data_i.pm;
    end else begin
      if (data_i.twelve) begin
        hour_b = (hour_b & rtcbcd_pkg::Mask5) | rtcbcd_pkg::Hr12Flag
                 | (data_i.pm ? rtcbcd_pkg::PmFlag : 8'h00);
      end
      if (data_i.century) begin
        mon_b = mon_b | rtcbcd_pkg::CenturyFlag;
      end
      rsp_d.regs_out = {data_i.val[rtcbcd_pkg::RegYear], mon_b,
                        data_i.val[rtcbcd_pkg::RegDate], data_i.val[rtcbcd_pkg::RegWday],
                        hour_b, data_i.val[rtcbcd_pkg::RegMin],
                        data_i.val[rtcbcd_pkg::RegSec]};
    end
  end

  assign ready_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.regs_out  = rsp_q.regs_out;
  assign rsp_o.sec_out   = rsp_q.sec_out;
  assign rsp_o.min_out   = rsp_q.min_out;
  assign rsp_o.hour_out  = rsp_q.hour_out;
  assign rsp_o.wday_out  = rsp_q.wday_out;
  assign rsp_o.mday_out  = rsp_q.mday_out;
  assign rsp_o.mon_out   = rsp_q.mon_out;
  assign rsp_o.yr_out    = rsp_q.yr_out;
  assign rsp_o.is_twelve = rsp_q.is_twelve;
  assign rsp_o.is_pm     = rsp_q.is_pm;

  // encode always stores a nonzero weekday byte, so nonzero regs means encode
  `RTCBCD_ASSERT_IMP(a_encode_zeroes_decode, valid_q && (rsp_q.regs_out != '0), rsp_q.sec_out == '0 && rsp_q.min_out == '0 && rsp_q.hour_out == '0 && rsp_q.wday_out == '0 && rsp_q.mday_out == '0 && rsp_q.mon_out == '0 && rsp_q.yr_out == '0 && !rsp_q.is_twelve && !rsp_q.is_pm, "decode fields set in encode result")
  `RTCBCD_ASSERT_IMP(a_pm_needs_twelve, valid_q && rsp_q.is_pm, rsp_q.is_twelve, "pm flag without 12-hour flag")
  `RTCBCD_ASSERT_IMP(a_decode_wday_nonzero, valid_q && (rsp_q.regs_out == '0), rsp_q.wday_out != '0, "decoded weekday out of range")

endmodule

// ----- rtl/rtc_time_bcd_codec.sv -----
// Top level of the RTC time BCD codec: three-stage conversion pipeline.
//
//  channel | dir | modport             | content
//  req_i   | in  | rtcbcd_in_if.sink   | mode, register bytes, binary time fields
//  rsp_o   | out | rtcbcd_out_if.source| encoded register bytes, decoded fields
//
// One request per cycle while rsp_o.ready is high; each result is registered in turn by
// the three register stages: prep, lane conversion, pack.
// Each stage holds one request and takes a new one when empty or when moving on.
// rsp_o.ready low stalls the stages back to req_i without loss or repeat.
// Reset clears the stage valid bits only; the stage data registers are not reset.
module rtc_time_bcd_codec (
  input  logic          clk_i,
  input  logic          rst_ni,
  rtcbcd_in_if.sink     req_i,
  rtcbcd_out_if.source  rsp_o
);

  rtcbcd_pkg::lane_t s1_data, s2_data;
  logic              s1_valid, s1_ready, s2_valid, s2_ready;

  rtcbcd_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .ready_i (s1_ready)
  );

  rtcbcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .ready_o (s1_ready),
    .valid_o (s2_valid),
    .data_o  (s2_data),
    .ready_i (s2_ready)
  );

  rtcbcd_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .ready_o (s2_ready),
    .rsp_o   (rsp_o)
  );

endmodule

// ----- sim/rtc_time_bcd_codec_tb.sv -----
// Self-checking testbench for the RTC time BCD codec: directed and random requests.
`timescale 1ns / 1ps

module rtc_time_bcd_codec_tb;

  typedef struct packed {
    rtcbcd_pkg::mode_e mode;
    logic [55:0]       time_regs;
    logic [5:0]        seconds;
    logic [5:0]        minutes;
    logic [4:0]        hours;
    logic [2:0]        weekday;
    logic [4:0]        date;
    logic [3:0]        month;
    logic [7:0]        year;
    logic              twelve_hour;
    logic              afternoon;
  } time_req_t;

  typedef struct packed {
    logic [55:0] regs_out;
    logic [7:0]  sec_out;
    logic [7:0]  min_out;
    logic [5:0]  hour_out;
    logic [2:0]  wday_out;
    logic [7:0]  mday_out;
    logic [6:0]  mon_out;
    logic [8:0]  yr_out;
    logic        is_twelve;
    logic        is_pm;
  } time_rsp_t;

  class time_codec_scoreboard;
    time_rsp_t   conv_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned n_decode;
    int unsigned n_encode;

    function new();
      mismatches = 0;
      checked    = 0;
      n_decode   = 0;
      n_encode   = 0;
    endfunction

    // digits are not range checked: 0xAF gives 10*10 + 15
    static function int unsigned bcd_val(logic [7:0] b);
      return 32'(b[3:0]) + 32'(b[7:4]) * 32'd10;
    endfunction

    static function logic [7:0] bin_bcd(int unsigned v);
      int unsigned x;
      x = v & 32'hFF;
      return 8'((x % 10) + (x / 10) * 16);
    endfunction

    static function time_rsp_t convert_time(time_req_t r);
      time_rsp_t   e;
      logic [7:0]  hb;
      logic [7:0]  mb;
      logic [7:0]  yb;
      logic [7:0]  hr_b;
      logic [7:0]  mon_b;
      int unsigned d;
      int unsigned yr;
      e = '0;
      if (r.mode == rtcbcd_pkg::ModeDecode) begin
        hb = r.time_regs[8*rtcbcd_pkg::RegHour +: 8];
        mb = r.time_regs[8*rtcbcd_pkg::RegMon +: 8];
        yb = r.time_regs[8*rtcbcd_pkg::RegYear +: 8];
        e.sec_out = 8'(bcd_val(r.time_regs[8*rtcbcd_pkg::RegSec +: 8]));
        e.min_out = 8'(bcd_val(r.time_regs[8*rtcbcd_pkg::RegMin +: 8]));
        if (hb[rtcbcd_pkg::Hr12Bit]) begin
          e.is_twelve = 1'b1;
          e.is_pm     = hb[rtcbcd_pkg::PmBit];
          e.hour_out  = 6'(bcd_val(hb & rtcbcd_pkg::Mask5));
        end else begin
          // 24-hour: bit 5 is a tens digit, not a PM flag
          e.hour_out = 6'(bcd_val(hb & rtcbcd_pkg::Mask6));
        end
        d = bcd_val(r.time_regs[8*rtcbcd_pkg::RegWday +: 8]);
        e.wday_out = 3'(((d + rtcbcd_pkg::WdayShift) % rtcbcd_pkg::WdayMod) + 1);
        e.mday_out = 8'(bcd_val(r.time_regs[8*rtcbcd_pkg::RegDate +: 8]));
        if (mb[rtcbcd_pkg::CenturyBit]) begin
          e.mon_out = 7'(bcd_val(mb & rtcbcd_pkg::Mask5));
          e.yr_out  = 9'(bcd_val(yb) + rtcbcd_pkg::YearOffset);
        end else begin
          e.mon_out = 7'(bcd_val(mb));
          e.yr_out  = 9'(bcd_val(yb));
        end
      end else begin
        yr    = 32'(r.year);
        mon_b = bin_bcd(32'(r.month));
        if (yr > rtcbcd_pkg::YearMax) begin
          yr    = yr - rtcbcd_pkg::YearOffset;
          mon_b = mon_b | rtcbcd_pkg::CenturyFlag;
        end
        hr_b = bin_bcd(32'(r.hours));
        if (r.twelve_hour) begin
          hr_b = (hr_b & rtcbcd_pkg::Mask5) | rtcbcd_pkg::Hr12Flag;
          if (r.afternoon) hr_b = hr_b | rtcbcd_pkg::PmFlag;
        end
        e.regs_out[8*rtcbcd_pkg::RegSec +: 8]  = bin_bcd(32'(r.seconds));
        e.regs_out[8*rtcbcd_pkg::RegMin +: 8]  = bin_bcd(32'(r.minutes));
        e.regs_out[8*rtcbcd_pkg::RegHour +: 8] = hr_b;
        e.regs_out[8*rtcbcd_pkg::RegWday +: 8] =
            bin_bcd(32'((r.weekday % rtcbcd_pkg::WdayMod) + 1));
        e.regs_out[8*rtcbcd_pkg::RegDate +: 8] = bin_bcd(32'(r.date));
        e.regs_out[8*rtcbcd_pkg::RegMon +: 8]  = mon_b;
        e.regs_out[8*rtcbcd_pkg::RegYear +: 8] = bin_bcd(yr);
      end
      return e;
    endfunction

    function void note_req(time_req_t r);
      if (r.mode == rtcbcd_pkg::ModeDecode) n_decode++;
      else n_encode++;
      conv_q.push_back(convert_time(r));
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d field %s expected 0x%0h got 0x%0h",
                   checked, name, want, got);
      end
    endfunction

    function void check_rsp(time_rsp_t got);
      time_rsp_t want;
      checked++;
      if (conv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d arrived with no request outstanding", checked);
        return;
      end
      want = conv_q.pop_front();
      cmp_field("regs_out",  64'(want.regs_out),  64'(got.regs_out));
      cmp_field("sec_out",   64'(want.sec_out),   64'(got.sec_out));
      cmp_field("min_out",   64'(want.min_out),   64'(got.min_out));
      cmp_field("hour_out",  64'(want.hour_out),  64'(got.hour_out));
      cmp_field("wday_out",  64'(want.wday_out),  64'(got.wday_out));
      cmp_field("mday_out",  64'(want.mday_out),  64'(got.mday_out));
      cmp_field("mon_out",   64'(want.mon_out),   64'(got.mon_out));
      cmp_field("yr_out",    64'(want.yr_out),    64'(got.yr_out));
      cmp_field("is_twelve", 64'(want.is_twelve), 64'(got.is_twelve));
      cmp_field("is_pm",     64'(want.is_pm),     64'(got.is_pm));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rtcbcd_in_if  req_if ();
  rtcbcd_out_if rsp_if ();

  rtc_time_bcd_codec u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  time_codec_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_reqs;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random back-pressure, or a counted hold-off when requested
  initial begin : rcv_proc
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left    = hold_left - 1;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    time_rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.regs_out  = rsp_if.regs_out;
      got.sec_out   = rsp_if.sec_out;
      got.min_out   = rsp_if.min_out;
      got.hour_out  = rsp_if.hour_out;
      got.wday_out  = rsp_if.wday_out;
      got.mday_out  = rsp_if.mday_out;
      got.mon_out   = rsp_if.mon_out;
      got.yr_out    = rsp_if.yr_out;
      got.is_twelve = rsp_if.is_twelve;
      got.is_pm     = rsp_if.is_pm;
      sb.check_rsp(got);
    end
  end

  function automatic time_req_t mk_decode(logic [55:0] regs);
    time_req_t r;
    r           = '0;
    r.mode      = rtcbcd_pkg::ModeDecode;
    r.time_regs = regs;
    return r;
  endfunction

  function automatic time_req_t mk_encode(int unsigned s, int unsigned m, int unsigned h,
                                          int unsigned w, int unsigned d, int unsigned mo,
                                          int unsigned y, bit twelve, bit pm);
    time_req_t r;
    r             = '0;
    r.mode        = rtcbcd_pkg::ModeEncode;
    r.seconds     = 6'(s);
    r.minutes     = 6'(m);
    r.hours       = 5'(h);
    r.weekday     = 3'(w);
    r.date        = 5'(d);
    r.month       = 4'(mo);
    r.year        = 8'(y);
    r.twelve_hour = twelve;
    r.afternoon   = pm;
    return r;
  endfunction

  // mostly plausible calendar values, the rest raw bit noise
  function automatic time_req_t rand_req();
    time_req_t  r;
    logic [7:0] hb;
    logic [7:0] mb;
    r.mode        = rtcbcd_pkg::mode_e'($urandom_range(1));
    r.time_regs   = 56'({$urandom, $urandom});
    r.seconds     = 6'($urandom);
    r.minutes     = 6'($urandom);
    r.hours       = 5'($urandom);
    r.weekday     = 3'($urandom);
    r.date        = 5'($urandom);
    r.month       = 4'($urandom);
    r.year        = 8'($urandom);
    r.twelve_hour = 1'($urandom);
    r.afternoon   = 1'($urandom);
    if ($urandom_range(99) < 75) begin
      if (r.mode == rtcbcd_pkg::ModeDecode) begin
        if ($urandom_range(1))
          hb = rtcbcd_pkg::Hr12Flag | ($urandom_range(1) ? rtcbcd_pkg::PmFlag : 8'h00) |
               time_codec_scoreboard::bin_bcd($urandom_range(12, 1));
        else
          hb = time_codec_scoreboard::bin_bcd($urandom_range(23));
        mb = time_codec_scoreboard::bin_bcd($urandom_range(12, 1)) |
             ($urandom_range(1) ? rtcbcd_pkg::CenturyFlag : 8'h00);
        r.time_regs[8*rtcbcd_pkg::RegSec +: 8]  =
            time_codec_scoreboard::bin_bcd($urandom_range(59));
        r.time_regs[8*rtcbcd_pkg::RegMin +: 8]  =
            time_codec_scoreboard::bin_bcd($urandom_range(59));
        r.time_regs[8*rtcbcd_pkg::RegHour +: 8] = hb;
        r.time_regs[8*rtcbcd_pkg::RegWday +: 8] =
            time_codec_scoreboard::bin_bcd($urandom_range(7, 1));
        r.time_regs[8*rtcbcd_pkg::RegDate +: 8] =
            time_codec_scoreboard::bin_bcd($urandom_range(31, 1));
        r.time_regs[8*rtcbcd_pkg::RegMon +: 8]  = mb;
        r.time_regs[8*rtcbcd_pkg::RegYear +: 8] =
            time_codec_scoreboard::bin_bcd($urandom_range(99));
      end else begin
        r.seconds = 6'($urandom_range(59));
        r.minutes = 6'($urandom_range(59));
        r.hours   = r.twelve_hour ? 5'($urandom_range(12, 1)) : 5'($urandom_range(23));
        r.weekday = 3'($urandom_range(7));
        r.date    = 5'($urandom_range(31, 1));
        r.month   = 4'($urandom_range(12, 1));
        r.year    = 8'($urandom_range(199));
      end
    end
    return r;
  endfunction

  // called and returns at a falling edge; valid stays high after acceptance
  task automatic send_req(time_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.mode        = r.mode;
    req_if.time_regs   = r.time_regs;
    req_if.seconds     = r.seconds;
    req_if.minutes     = r.minutes;
    req_if.hours       = r.hours;
    req_if.weekday     = r.weekday;
    req_if.date        = r.date;
    req_if.month       = r.month;
    req_if.year        = r.year;
    req_if.twelve_hour = r.twelve_hour;
    req_if.afternoon   = r.afternoon;
    req_if.valid       = 1'b1;
    do @(posedge clk); while (!req_if.ready);
    sb.note_req(r);
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_req(rand_req());
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.conv_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n              = 1'b0;
    hold_reqs          = 0;
    send_idle_pct      = 14;
    rcv_idle_pct       = 85;
    req_if.valid       = 1'b0;
    req_if.mode        = rtcbcd_pkg::ModeDecode;
    req_if.time_regs   = '0;
    req_if.seconds     = '0;
    req_if.minutes     = '0;
    req_if.hours       = '0;
    req_if.weekday     = '0;
    req_if.date        = '0;
    req_if.month       = '0;
    req_if.year        = '0;
    req_if.twelve_hour = 1'b0;
    req_if.afternoon   = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed decode: byte order is year..seconds from left to right
    send_req(mk_decode(56'h0));
    send_req(mk_decode(56'hFF_FFFF_FFFF_FFFF));
    send_req(mk_decode(56'h25_06_15_03_72_30_45));  // 12-hour PM, 12 o'clock
    send_req(mk_decode(56'h25_06_15_03_41_00_00));  // 12-hour AM
    send_req(mk_decode(56'h25_06_15_03_23_59_59));  // 24-hour, bit 5 is a digit
    send_req(mk_decode(56'h99_92_28_07_12_00_00));  // century flag, year 199
    send_req(mk_decode(56'hFF_9F_31_01_00_00_00));  // century, year above 255
    send_req(mk_decode(56'h99_7F_31_00_3F_00_00));  // month without century
    send_req(mk_decode(56'hAA_1A_BF_FF_5F_AF_FA));  // nibbles above 9
    // directed encode
    send_req(mk_encode(0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_req(mk_encode(63, 63, 31, 7, 31, 15, 255, 1'b1, 1'b1));
    send_req(mk_encode(59, 59, 23, 6, 31, 12, 99, 1'b0, 1'b0));
    send_req(mk_encode(0, 0, 0, 1, 1, 1, 100, 1'b0, 1'b0));
    send_req(mk_encode(30, 15, 9, 2, 15, 7, 199, 1'b0, 1'b0));
    send_req(mk_encode(30, 15, 9, 3, 15, 7, 200, 1'b0, 1'b0));  // tens digit above 9
    send_req(mk_encode(0, 0, 12, 4, 10, 3, 24, 1'b1, 1'b0));    // 12 AM
    send_req(mk_encode(0, 0, 11, 5, 10, 3, 24, 1'b1, 1'b1));    // 11 PM
    send_req(mk_encode(0, 0, 23, 6, 10, 3, 24, 1'b0, 1'b1));    // PM flag ignored in 24-hour
    send_req(mk_encode(1, 2, 3, 0, 4, 5, 6, 1'b0, 1'b0));
    drain();

    send_random(165);
    drain();

    send_idle_pct = 85;
    rcv_idle_pct  = 14;
    send_random(165);
    drain();

    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    send_random(40);
    // long receiver hold-off while requests keep coming, fills the pipeline
    req_if.valid = 1'b0;
    @(posedge clk);
    hold_reqs = hold_reqs + 1;
    @(negedge clk);
    send_random(40);
    drain();
    send_random(90);
    drain();

    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d decode and %0d encode requests,",
             sb.checked, sb.n_decode, sb.n_encode);
    $display("over three idle mixes, a full-pipeline stall and drained pauses.");
    if (sb.mismatches == 0 && sb.conv_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", sb.conv_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
